// File: hw/rtl/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

	localparam logic [7:0] HDR_SUM = 8'hFD;
	localparam logic [7:0] TRL_SUM = 8'hDF;
	localparam logic [7:0] HDR_XOR = 8'h7B;
	localparam logic [7:0] TRL_XOR = 8'h7D;

	localparam int POS_W = 5;
	localparam logic [POS_W-1:0] LEN_SUM = 5'd19;
	localparam logic [POS_W-1:0] LEN_XOR = 5'd11;
	localparam logic [POS_W-1:0] LAST_DIST_SUM = 5'd12;
	localparam logic [POS_W-1:0] LAST_DIST_XOR = 5'd8;

	localparam int NUM_DIST = 6;
	localparam int WORD_IDX_W = $clog2(NUM_DIST);
	localparam int DIST_W = 16;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_CHECK = 2'd2;
	localparam logic [1:0] KIND_TRAIL = 2'd3;

	localparam logic [1:0] ST_GOOD = 2'd0;
	localparam logic [1:0] ST_BAD_TRAILER = 2'd1;
	localparam logic [1:0] ST_BAD_SUM = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic xmode;
		logic [7:0] data;
		logic store;
		logic [WORD_IDX_W-1:0] word;
		logic hi;
	} op_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/sensor_frame_deframer_core.sv
// Serial frame deframer for two sensor modes.
// Input channel: one received byte (rx_byte) per word, taken when in_valid is
// high and in_stall is low. Bytes are dropped until the header of the mode
// selected by the one-bit register (cfg_wr_en / cfg_wr_data) arrives.
// Output channel: one word per completed frame, status plus six distances,
// taken when out_valid is high and out_stall is low; it holds while stalled.
// Throughput: one byte per cycle, sustained, with the output taken as offered.
// After a frame's trailer byte is accepted, its trailer op is held in the queue
// and its result then in the output register. The front tracks frame position and
// sends one op per in-frame byte into a small queue; the back keeps checksum and
// distances and owns the output register, so only a stalled result holds the
// queue, and in_stall rises once the queue fills behind it.
// Reset clears the mode to 0, returns the front to hunting, and empties the
// queue and the output register.
`default_nettype none
module sensor_frame_deframer_core
	import sfd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic cfg_wr_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] rx_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [DIST_W-1:0] dist_a,
	output logic [DIST_W-1:0] dist_b,
	output logic [DIST_W-1:0] dist_c,
	output logic [DIST_W-1:0] dist_d,
	output logic [DIST_W-1:0] dist_e,
	output logic [DIST_W-1:0] dist_f
);

	logic sensor_mode_q;
	logic accept;
	logic push;
	logic pop;
	op_t front_op;
	op_t back_op;
	q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			sensor_mode_q <= cfg_wr_data;
		end
	end

	assign in_stall = q_stat.full;
	assign accept = in_valid && !in_stall;

	sfd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_byte(rx_byte),
		.sensor_mode(sensor_mode_q),
		.push(push),
		.op(front_op)
	);

	sfd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_op(front_op),
		.pop(pop),
		.rd_op(back_op),
		.stat(q_stat)
	);

	sfd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.op(back_op),
		.pop(pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.status(status),
		.dist_a(dist_a),
		.dist_b(dist_b),
		.dist_c(dist_c),
		.dist_d(dist_d),
		.dist_e(dist_e),
		.dist_f(dist_f)
	);

	a_bad_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_GOOD |->
			dist_a == '0 && dist_b == '0 && dist_c == '0 &&
			dist_d == '0 && dist_e == '0 && dist_f == '0)
		else $error("bad frame carries distances");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_GOOD || status == ST_BAD_TRAILER ||
			status == ST_BAD_SUM)
		else $error("status code out of range");

	a_result_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_stat.valid))
		else $error("result without a queued trailer");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("push into a full queue");

endmodule
`default_nettype wire

// File: hw/rtl/sfd_front.sv
`default_nettype none
module sfd_front
	import sfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [7:0] rx_byte,
	input wire logic sensor_mode,
	output logic push,
	output op_t op
);

	logic in_frame_q;
	logic [POS_W-1:0] pos_q;
	logic in_frame_d;
	logic [POS_W-1:0] pos_d;
	logic op_valid;
	logic [POS_W-1:0] len;
	logic [POS_W-1:0] last_dist;
	logic [POS_W-1:0] pos_m1;
	logic [7:0] hdr;

	assign len = sensor_mode ? LEN_XOR : LEN_SUM;
	assign last_dist = sensor_mode ? LAST_DIST_XOR : LAST_DIST_SUM;
	assign hdr = sensor_mode ? HDR_XOR : HDR_SUM;
	assign pos_m1 = pos_q - POS_W'(1);

	always_comb begin
		in_frame_d = in_frame_q;
		pos_d = pos_q;
		op_valid = 1'b0;
		op.kind = KIND_DATA;
		op.xmode = sensor_mode;
		op.data = rx_byte;
		op.store = 1'b0;
		op.word = WORD_IDX_W'(pos_m1 >> 1);
		op.hi = pos_q[0];
		if (!in_frame_q) begin
			if (rx_byte == hdr) begin
				in_frame_d = 1'b1;
				pos_d = POS_W'(1);
				op_valid = 1'b1;
				op.kind = KIND_START;
			end
		end else if (pos_q >= len) begin
			in_frame_d = 1'b0;
			pos_d = '0;
		end else if (pos_q < len - POS_W'(2)) begin
			op_valid = 1'b1;
			op.kind = KIND_DATA;
			op.store = (pos_q <= last_dist);
			pos_d = pos_q + POS_W'(1);
		end else if (pos_q == len - POS_W'(2)) begin
			op_valid = 1'b1;
			op.kind = KIND_CHECK;
			pos_d = pos_q + POS_W'(1);
		end else begin
			op_valid = 1'b1;
			op.kind = KIND_TRAIL;
			in_frame_d = 1'b0;
			pos_d = '0;
		end
	end

	assign push = accept && op_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q <= '0;
		end else if (accept) begin
			in_frame_q <= in_frame_d;
			pos_q <= pos_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/sfd_queue.sv
`default_nettype none
module sfd_queue
	import sfd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire op_t wr_op,
	input wire logic pop,
	output op_t rd_op,
	output q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign stat.valid = (cnt_q != '0);
	assign stat.full = (cnt_q == CNT_W'(DEPTH));
	assign do_push = push && !stat.full;
	assign do_pop = pop && stat.valid;
	assign rd_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/sfd_back.sv
`default_nettype none
module sfd_back
	import sfd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire q_stat_t q_stat,
	input wire op_t op,
	output logic pop,
	input wire logic out_stall,
	output logic out_valid,
	output logic [1:0] status,
	output logic [DIST_W-1:0] dist_a,
	output logic [DIST_W-1:0] dist_b,
	output logic [DIST_W-1:0] dist_c,
	output logic [DIST_W-1:0] dist_d,
	output logic [DIST_W-1:0] dist_e,
	output logic [DIST_W-1:0] dist_f
);

	logic [7:0] acc_q;
	logic matched_q;
	logic [DIST_W-1:0] dist_q [NUM_DIST];
	logic out_valid_q;
	logic [1:0] status_q;
	logic [DIST_W-1:0] res_q [NUM_DIST];
	logic [1:0] status_d;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign pop = q_stat.valid && ((op.kind != KIND_TRAIL) || out_free);

	always_comb begin
		if (op.data != (op.xmode ? TRL_XOR : TRL_SUM)) begin
			status_d = ST_BAD_TRAILER;
		end else if (!matched_q) begin
			status_d = ST_BAD_SUM;
		end else begin
			status_d = ST_GOOD;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			unique case (op.kind)
				KIND_START: begin
					acc_q <= op.data;
					matched_q <= 1'b0;
					for (int k = 0; k < NUM_DIST; k++) begin
						dist_q[k] <= '0;
					end
				end
				KIND_DATA: begin
					acc_q <= op.xmode ? (acc_q ^ op.data) : (acc_q + op.data);
					for (int k = 0; k < NUM_DIST; k++) begin
						if (op.store && op.word == WORD_IDX_W'(k)) begin
							if (op.hi) begin
								dist_q[k][15:8] <= op.data;
							end else begin
								dist_q[k][7:0] <= op.data;
							end
						end
					end
				end
				KIND_CHECK: begin
					matched_q <= (acc_q == op.data);
				end
				KIND_TRAIL: begin
					status_q <= status_d;
					for (int k = 0; k < NUM_DIST; k++) begin
						res_q[k] <= (status_d == ST_GOOD && !(op.xmode && k >= 4))
							? dist_q[k] : '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && op.kind == KIND_TRAIL) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign dist_a = res_q[0];
	assign dist_b = res_q[1];
	assign dist_c = res_q[2];
	assign dist_d = res_q[3];
	assign dist_e = res_q[4];
	assign dist_f = res_q[5];

endmodule
`default_nettype wire
